/* design/cfrt_pkg.sv */
// Shared constants, field layout and verdict codes of the chunked frame reassembly tracker.
package cfrt_pkg;

    // Limits
    localparam int unsigned MAX_WIDTH      = 1024;
    localparam int unsigned MAX_HEIGHT     = 1024;
    localparam int unsigned MAX_CHUNKS     = 1024;
    localparam int unsigned MAX_COMPRESSED = 2097152;

    // Defaults after reset
    localparam int unsigned DEFAULT_WIDTH  = 640;
    localparam int unsigned DEFAULT_HEIGHT = 480;

    // Chunk map organization: rows of bits in one memory
    localparam int unsigned MAP_ROW_BITS = 32;
    localparam int unsigned MAP_ROWS     = MAX_CHUNKS / MAP_ROW_BITS;
    localparam int unsigned BIT_SEL_W    = $clog2(MAP_ROW_BITS);
    localparam int unsigned ROW_SEL_W    = $clog2(MAP_ROWS);
    localparam int unsigned CHUNK_IDX_W  = BIT_SEL_W + ROW_SEL_W;

    // Field widths
    localparam int unsigned DIM_W    = 11;
    localparam int unsigned RAW_W    = 21;
    localparam int unsigned EXTENT_W = 22;
    localparam int unsigned CNT_W    = 11;
    localparam int unsigned PLEN_W   = 13;

    // Input tdata layout (lowest bit of each field)
    localparam int unsigned IN_FNUM_LSB  = 0;
    localparam int unsigned IN_W_LSB     = 32;
    localparam int unsigned IN_H_LSB     = 48;
    localparam int unsigned IN_IDX_LSB   = 64;
    localparam int unsigned IN_TOTAL_LSB = 80;
    localparam int unsigned IN_START_LSB = 96;
    localparam int unsigned IN_CLEN_LSB  = 128;
    localparam int unsigned IN_PLEN_LSB  = 160;
    localparam int unsigned IN_TDATA_W   = 176;
    localparam int unsigned IN_TUSER_W   = 1;

    // Output tdata / tuser widths
    localparam int unsigned OUT_TDATA_W = 152;
    localparam int unsigned OUT_TUSER_W = 4;

    // Verdict codes
    localparam logic [2:0] V_NEW        = 3'd0;
    localparam logic [2:0] V_DUPLICATE  = 3'd1;
    localparam logic [2:0] V_EMPTY      = 3'd2;
    localparam logic [2:0] V_BAD_HEADER = 3'd3;
    localparam logic [2:0] V_MISMATCH   = 3'd4;
    localparam logic [2:0] V_BAD_INDEX  = 3'd5;
    localparam logic [2:0] V_SIZE       = 3'd6;
    localparam logic [2:0] V_RANGE      = 3'd7;

endpackage

/* design/chunked_frame_reassembly_tracker_top.sv */
// Top level of the chunked frame reassembly tracker: header checks and chunk map read-modify-write.
//
// Usage:
//   Slave stream (i_s_axis_*) carries one parsed chunk header per packet; the
//   codec kind travels in tuser. Master stream (o_m_axis_*) returns exactly one
//   result transaction per header: the verdict and the codec of a completed
//   frame travel in tuser, the granted write, frame begin/done/lost flags,
//   completed frame description and the dropped frame count in tdata.
//   Flow: a header is accepted only in the idle state; accepting it captures
//   the header and reads its chunk map row into a register. The check state
//   then checks the header, writes the modified row back and loads the result
//   into the output register when that register is free; the next header is
//   accepted only after that commit.
//   Reset: i_rst_n low clears the frame state and the per-row valid bits of
//   the chunk map at once; no clearing pass is needed and the block accepts a
//   header in the first cycle after reset. A new frame clears the map the same
//   way, by dropping all row valid bits at once.
//   Stall: a held result sits in the output register; one more header is taken
//   and checked, and its result waits until the output register is free.
module chunked_frame_reassembly_tracker_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // frame_number, image_width, image_height, chunk_number, chunk_total,
    // chunk_start, chunk_length, payload_length, zero fill
    input  logic [cfrt_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // codec_kind
    input  logic [cfrt_pkg::IN_TUSER_W-1:0]    i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // store_offset, store_length, frame_begun, frame_done, frame_lost,
    // done_frame_number, done_width, done_height, done_data_bytes,
    // lost_frames, zero fill
    output logic [cfrt_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // verdict, done_codec
    output logic [cfrt_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser
);
    import cfrt_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // Control and frame state
    logic                     r_state;
    logic                     r_assembling;
    logic [31:0]              r_active_fnum;
    logic                     r_active_codec;
    logic [DIM_W-1:0]         r_active_width;
    logic [DIM_W-1:0]         r_active_height;
    logic [RAW_W-1:0]         r_raw_bytes;
    logic [CNT_W-1:0]         r_chunks_expected;
    logic [CNT_W-1:0]         r_chunks_seen;
    logic [EXTENT_W-1:0]      r_data_extent;
    logic [31:0]              r_dropped;
    logic [MAP_ROWS-1:0]      r_row_valid;

    // Captured header
    logic [31:0]              r_fnum;
    logic [15:0]              r_w;
    logic [15:0]              r_h;
    logic                     r_codec;
    logic [15:0]              r_idx;
    logic [15:0]              r_total;
    logic [31:0]              r_start;
    logic [31:0]              r_clen;
    logic [PLEN_W-1:0]        r_plen;

    // Chunk map memory
    logic [MAP_ROW_BITS-1:0]  r_map_mem [MAP_ROWS];
    logic [MAP_ROW_BITS-1:0]  r_map_rd;

    // Output register
    logic                     r_out_valid;
    logic [OUT_TDATA_W-1:0]   r_out_data;
    logic [OUT_TUSER_W-1:0]   r_out_user;

    // Next values
    logic                     n_assembling;
    logic [31:0]              n_active_fnum;
    logic                     n_active_codec;
    logic [DIM_W-1:0]         n_active_width;
    logic [DIM_W-1:0]         n_active_height;
    logic [RAW_W-1:0]         n_raw_bytes;
    logic [CNT_W-1:0]         n_chunks_expected;
    logic [CNT_W-1:0]         n_chunks_seen;
    logic [EXTENT_W-1:0]      n_data_extent;
    logic [31:0]              n_dropped;
    logic [MAP_ROWS-1:0]      n_row_valid;
    logic [2:0]               n_verdict;
    logic [MAP_ROW_BITS-1:0]  n_row_data;

    // Working signals
    logic                     s_accept;
    logic                     s_commit;
    logic                     shape_bad;
    logic                     empty;
    logic                     new_frame;
    logic                     dims_bad;
    logic                     lost_now;
    logic                     take_frame;
    logic                     seen_bit;
    logic                     done;
    logic [32:0]              chunk_end;
    logic [2*DIM_W-1:0]       area;
    logic [ROW_SEL_W-1:0]     row_sel;
    logic [BIT_SEL_W-1:0]     bit_sel;
    logic [MAP_ROW_BITS-1:0]  eff_row;
    logic [MAP_ROW_BITS-1:0]  bit_mask;
    logic                     eff_codec;
    logic [CNT_W-1:0]         eff_expected;
    logic [CNT_W-1:0]         eff_seen;
    logic [RAW_W-1:0]         eff_raw;
    logic [EXTENT_W-1:0]      eff_extent;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign s_commit        = (r_state == S_EXEC) && (!r_out_valid || i_m_axis_tready);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // Capture the header on accept
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_fnum  <= i_s_axis_tdata[IN_FNUM_LSB  +: 32];
            r_w     <= i_s_axis_tdata[IN_W_LSB     +: 16];
            r_h     <= i_s_axis_tdata[IN_H_LSB     +: 16];
            r_idx   <= i_s_axis_tdata[IN_IDX_LSB   +: 16];
            r_total <= i_s_axis_tdata[IN_TOTAL_LSB +: 16];
            r_start <= i_s_axis_tdata[IN_START_LSB +: 32];
            r_clen  <= i_s_axis_tdata[IN_CLEN_LSB  +: 32];
            r_plen  <= i_s_axis_tdata[IN_PLEN_LSB  +: PLEN_W];
            r_codec <= i_s_axis_tuser[0];
        end
    end

    // Chunk map memory: row read on accept, modified row written on commit of a new chunk
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_map_rd <= r_map_mem[i_s_axis_tdata[IN_IDX_LSB+BIT_SEL_W +: ROW_SEL_W]];
        end
        if (s_commit && (n_verdict == V_NEW)) begin
            r_map_mem[row_sel] <= n_row_data;
        end
    end

    // Check the header against the active frame
    always_comb begin
        row_sel   = r_idx[BIT_SEL_W +: ROW_SEL_W];
        bit_sel   = r_idx[BIT_SEL_W-1:0];
        bit_mask  = MAP_ROW_BITS'(1) << bit_sel;
        chunk_end = {1'b0, r_start} + {1'b0, r_clen};
        area      = r_w[DIM_W-1:0] * r_h[DIM_W-1:0];

        shape_bad = (r_total == 16'd0) || (32'(r_total) > MAX_CHUNKS) || (r_idx >= r_total);
        empty     = (r_plen == '0);
        new_frame = !r_assembling || (r_fnum != r_active_fnum);
        dims_bad  = (r_w == 16'd0) || (r_h == 16'd0) ||
                    (32'(r_w) > MAX_WIDTH) || (32'(r_h) > MAX_HEIGHT);
        lost_now  = !shape_bad && !empty && new_frame && r_assembling &&
                    (r_chunks_expected != '0) && (r_chunks_seen < r_chunks_expected);
        take_frame = !shape_bad && !empty && new_frame && !dims_bad;

        // Frame state as seen after a possible frame start
        if (take_frame) begin
            eff_codec    = r_codec;
            eff_expected = r_total[CNT_W-1:0];
            eff_seen     = '0;
            eff_raw      = area[RAW_W-1:0];
            eff_extent   = '0;
            eff_row      = '0;
        end else begin
            eff_codec    = r_active_codec;
            eff_expected = r_chunks_expected;
            eff_seen     = r_chunks_seen;
            eff_raw      = r_raw_bytes;
            eff_extent   = r_data_extent;
            eff_row      = r_row_valid[row_sel] ? r_map_rd : '0;
        end
        seen_bit = |(eff_row & bit_mask);

        // Verdict in priority order
        if (shape_bad) begin
            n_verdict = V_BAD_HEADER;
        end else if (empty) begin
            n_verdict = V_EMPTY;
        end else if (new_frame && dims_bad) begin
            n_verdict = V_BAD_HEADER;
        end else if ((r_codec != eff_codec) || (r_total != 16'(eff_expected))) begin
            n_verdict = V_MISMATCH;
        end else if ((r_idx >= 16'(eff_expected)) || (32'(r_idx) >= MAX_CHUNKS)) begin
            n_verdict = V_BAD_INDEX;
        end else if (r_clen != 32'(r_plen)) begin
            n_verdict = V_SIZE;
        end else if (!eff_codec && ((r_start >= 32'(eff_raw)) ||
                                    (chunk_end > 33'(eff_raw)))) begin
            n_verdict = V_RANGE;
        end else if (eff_codec && (chunk_end > 33'(MAX_COMPRESSED))) begin
            n_verdict = V_RANGE;
        end else if (seen_bit) begin
            n_verdict = V_DUPLICATE;
        end else begin
            n_verdict = V_NEW;
        end

        n_row_data = eff_row | bit_mask;

        // Advance frame state
        n_active_codec    = eff_codec;
        n_chunks_expected = eff_expected;
        n_raw_bytes       = eff_raw;
        n_chunks_seen     = eff_seen + CNT_W'(n_verdict == V_NEW);
        n_active_fnum     = take_frame ? r_fnum : r_active_fnum;
        n_active_width    = take_frame ? r_w[DIM_W-1:0] : r_active_width;
        n_active_height   = take_frame ? r_h[DIM_W-1:0] : r_active_height;
        if ((n_verdict == V_NEW) && (chunk_end > 33'(eff_extent))) begin
            n_data_extent = chunk_end[EXTENT_W-1:0];
        end else begin
            n_data_extent = eff_extent;
        end

        n_row_valid = take_frame ? '0 : r_row_valid;
        if (n_verdict == V_NEW) begin
            n_row_valid[row_sel] = 1'b1;
        end

        done = ((n_verdict == V_NEW) || (n_verdict == V_DUPLICATE)) &&
               (n_chunks_seen == n_chunks_expected);

        if (shape_bad || empty) begin
            n_assembling = r_assembling;
        end else if (new_frame && dims_bad) begin
            n_assembling = 1'b0;
        end else begin
            n_assembling = !done;
        end

        n_dropped = (lost_now && (r_dropped != 32'hFFFF_FFFF)) ? r_dropped + 32'd1 : r_dropped;
    end

    // Sequence one header at a time: accept, then commit when output is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_assembling      <= 1'b0;
            r_active_fnum     <= '0;
            r_active_codec    <= 1'b0;
            r_active_width    <= DIM_W'(DEFAULT_WIDTH);
            r_active_height   <= DIM_W'(DEFAULT_HEIGHT);
            r_raw_bytes       <= RAW_W'(DEFAULT_WIDTH * DEFAULT_HEIGHT);
            r_chunks_expected <= '0;
            r_chunks_seen     <= '0;
            r_data_extent     <= '0;
            r_dropped         <= '0;
            r_row_valid       <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (s_accept) begin
                r_state <= S_EXEC;
            end
            if (s_commit) begin
                r_state           <= S_IDLE;
                r_assembling      <= n_assembling;
                r_active_fnum     <= n_active_fnum;
                r_active_codec    <= n_active_codec;
                r_active_width    <= n_active_width;
                r_active_height   <= n_active_height;
                r_raw_bytes       <= n_raw_bytes;
                r_chunks_expected <= n_chunks_expected;
                r_chunks_seen     <= n_chunks_seen;
                r_data_extent     <= n_data_extent;
                r_dropped         <= n_dropped;
                r_row_valid       <= n_row_valid;
                r_out_valid       <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result transaction
    always_ff @(posedge i_clk) begin
        if (s_commit) begin
            r_out_data <= {
                7'd0,
                n_dropped,
                done ? n_data_extent : EXTENT_W'(0),
                done ? n_active_height : DIM_W'(0),
                done ? n_active_width : DIM_W'(0),
                done ? n_active_fnum : 32'd0,
                lost_now,
                done,
                take_frame,
                (n_verdict == V_NEW) ? r_plen : PLEN_W'(0),
                (n_verdict == V_NEW) ? r_start[RAW_W-1:0] : RAW_W'(0)
            };
            r_out_user <= {done & n_active_codec, n_verdict};
        end
    end

    // Checks
    a_accept_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_EXEC))
        else $error("header accepted but no check cycle followed");

    a_new_chunk_marks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_commit && (n_verdict == V_NEW)) |=> r_row_valid[$past(row_sel)])
        else $error("granted chunk left its map row invalid");

    a_seen_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunks_seen <= r_chunks_expected)
        else $error("more chunks seen than expected");

    a_dropped_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_dropped >= $past(r_dropped)))
        else $error("dropped frame count went down");

    a_done_clears_assembling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_commit && done) |=> !r_assembling)
        else $error("frame still assembling after completion");

endmodule
